[src/tzac_pkg.sv]
// tzac_pkg: shared constants and the arctangent table for the zigzag angle check
// no dependencies
`default_nettype none
package tzac_pkg;

    localparam int COORD_BITS_DEF = 20;
    localparam int ATAN_ITER_DEF  = 16;

    // internal angle: 2^22 units per degree
    localparam int ZW     = 32;
    localparam int WRAP_W = 33;
    localparam int ANG_W  = 15;
    localparam int PROD_W = 28;
    localparam int CFG_W  = 28;
    localparam int APB_AW = 3;

    localparam logic signed [ZW-1:0]     DEG90     = 32'sd377487360;
    localparam logic signed [WRAP_W-1:0] HALF_TURN = 33'sd754974720;
    localparam logic signed [WRAP_W-1:0] FULL_TURN = 33'sd1509949440;
    localparam logic signed [WRAP_W-1:0] ROUND_ADD = 33'sd32768;

    localparam logic [CFG_W-1:0] PROD_MIN_RST = 28'd0;
    localparam logic [CFG_W-1:0] PROD_MAX_RST = 28'd132710400;

    typedef enum logic {
        t_reg_prod_min = 1'b0,
        t_reg_prod_max = 1'b1
    } t_reg_idx;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = 32'sd188743680;
            5'd1:    v = 32'sd111421900;
            5'd2:    v = 32'sd58872272;
            5'd3:    v = 32'sd29884485;
            5'd4:    v = 32'sd15000234;
            5'd5:    v = 32'sd7507429;
            5'd6:    v = 32'sd3754631;
            5'd7:    v = 32'sd1877430;
            5'd8:    v = 32'sd938729;
            5'd9:    v = 32'sd469367;
            5'd10:   v = 32'sd234683;
            5'd11:   v = 32'sd117342;
            5'd12:   v = 32'sd58671;
            5'd13:   v = 32'sd29335;
            5'd14:   v = 32'sd14668;
            5'd15:   v = 32'sd7334;
            5'd16:   v = 32'sd3667;
            5'd17:   v = 32'sd1833;
            5'd18:   v = 32'sd917;
            5'd19:   v = 32'sd458;
            5'd20:   v = 32'sd229;
            5'd21:   v = 32'sd115;
            5'd22:   v = 32'sd57;
            5'd23:   v = 32'sd29;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[src/tzac_lane.sv]
// tzac_lane: one pipelined vectoring cordic lane, azimuth of the vector from p to q
// depends on tzac_pkg
`default_nettype none
module tzac_lane #(
    parameter int COORD_BITS      = tzac_pkg::COORD_BITS_DEF,
    parameter int ATAN_ITERATIONS = tzac_pkg::ATAN_ITER_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic [ATAN_ITERATIONS:0]             i_en,
    input  wire logic signed [COORD_BITS-1:0]         i_px,
    input  wire logic signed [COORD_BITS-1:0]         i_py,
    input  wire logic signed [COORD_BITS-1:0]         i_qx,
    input  wire logic signed [COORD_BITS-1:0]         i_qy,
    output logic signed [tzac_pkg::ZW-1:0]            o_z
);
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int DW     = COORD_BITS + ATAN_ITERATIONS + 4;
    localparam int IT     = ATAN_ITERATIONS;

    logic signed [DW-1:0]           r_x [IT+1];
    logic signed [DW-1:0]           r_y [IT+1];
    logic signed [tzac_pkg::ZW-1:0] r_z [IT+1];
    logic                           r_zero [IT+1];

    logic signed [DIFF_W-1:0]       dx, dy;
    logic signed [DW-1:0]           sx, sy, n_x, n_y;
    logic signed [tzac_pkg::ZW-1:0] n_z;

    // difference, scaling and turn into the right half plane
    always_comb begin
        dx = DIFF_W'(i_qx) - DIFF_W'(i_px);
        dy = DIFF_W'(i_qy) - DIFF_W'(i_py);
        sx = DW'(dx) <<< IT;
        sy = DW'(dy) <<< IT;
        n_x = sx;
        n_y = sy;
        n_z = '0;
        if (sx < 0) begin
            if (sy >= 0) begin
                n_x = sy;
                n_y = -sx;
                n_z = tzac_pkg::DEG90;
            end else begin
                n_x = -sy;
                n_y = sx;
                n_z = -tzac_pkg::DEG90;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x[0]    <= n_x;
            r_y[0]    <= n_y;
            r_z[0]    <= n_z;
            r_zero[0] <= (dx == 0) && (dy == 0);
        end
    end

    for (genvar i = 0; i < IT; i++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en[i+1]) begin
                r_zero[i+1] <= r_zero[i];
                if (!r_y[i][DW-1]) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + tzac_pkg::atan_entry(5'(i));
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - tzac_pkg::atan_entry(5'(i));
                end
            end
        end
    end

    // zero vector has azimuth zero
    assign o_z = r_zero[IT] ? '0 : r_z[IT];

endmodule
`default_nettype wire

[src/tzac_merge.sv]
// tzac_merge: angle differences, wrap, rounding, product and bound check
// depends on tzac_pkg
`default_nettype none
module tzac_merge (
    input  wire logic                                   i_clk,
    input  wire logic [3:0]                             i_en,
    input  wire logic signed [tzac_pkg::ZW-1:0]         i_z_out,
    input  wire logic signed [tzac_pkg::ZW-1:0]         i_z_mid,
    input  wire logic signed [tzac_pkg::ZW-1:0]         i_z_in,
    input  wire logic signed [tzac_pkg::CFG_W-1:0]      i_prod_min,
    input  wire logic signed [tzac_pkg::CFG_W-1:0]      i_prod_max,
    output logic                                        o_compatible,
    output logic signed [tzac_pkg::ANG_W-1:0]           o_first_angle,
    output logic signed [tzac_pkg::ANG_W-1:0]           o_second_angle,
    output logic signed [tzac_pkg::PROD_W-1:0]          o_angle_product
);
    localparam int WW = tzac_pkg::WRAP_W;
    localparam int AW = tzac_pkg::ANG_W;
    localparam int PW = tzac_pkg::PROD_W;

    logic signed [WW-1:0] d1, d2, n_w1, n_w2, r_w1, r_w2, s1, s2;
    logic signed [AW-1:0] r_a1, r_a2, r_b1, r_b2, r_c1, r_c2;
    logic signed [2*AW-1:0] prod;
    logic signed [PW-1:0] r_prod, r_out_prod;
    logic                 r_out_ok;

    function automatic logic signed [WW-1:0] wrap(input logic signed [WW-1:0] d);
        logic signed [WW-1:0] r;
        r = d;
        if (d > tzac_pkg::HALF_TURN)
            r = d - tzac_pkg::FULL_TURN;
        else if (d <= -tzac_pkg::HALF_TURN)
            r = d + tzac_pkg::FULL_TURN;
        return r;
    endfunction

    always_comb begin
        d1   = WW'(i_z_out) - WW'(i_z_mid);
        d2   = WW'(i_z_mid) - WW'(i_z_in);
        n_w1 = wrap(d1);
        n_w2 = wrap(d2);
        s1   = r_w1 + tzac_pkg::ROUND_ADD;
        s2   = r_w2 + tzac_pkg::ROUND_ADD;
        prod = r_a1 * r_a2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_w1 <= n_w1;
            r_w2 <= n_w2;
        end
        if (i_en[1]) begin
            r_a1 <= s1[AW+15:16];
            r_a2 <= s2[AW+15:16];
        end
        if (i_en[2]) begin
            r_prod <= prod[PW-1:0];
            r_b1   <= r_a1;
            r_b2   <= r_a2;
        end
        if (i_en[3]) begin
            r_out_ok   <= (r_prod >= i_prod_min) && (r_prod <= i_prod_max);
            r_out_prod <= r_prod;
            r_c1       <= r_b1;
            r_c2       <= r_b2;
        end
    end

    assign o_compatible    = r_out_ok;
    assign o_first_angle   = r_c1;
    assign o_second_angle  = r_c2;
    assign o_angle_product = r_out_prod;

endmodule
`default_nettype wire

[src/track_zigzag_angle_check.sv]
// track_zigzag_angle_check: four-hit curvature sign consistency cut
// throughput: one word per cycle while the output is not stalled, set by the fully pipelined cordic lanes
// each stage holds or moves on its own, so bubbles close up under a stalled output
// reset (synchronous, active low) empties the pipeline and restores the product bounds
`default_nettype none
module track_zigzag_angle_check #(
    parameter int COORD_BITS      = tzac_pkg::COORD_BITS_DEF,
    parameter int ATAN_ITERATIONS = tzac_pkg::ATAN_ITER_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // apb configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tzac_pkg::APB_AW-1:0]       paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    // input words
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [COORD_BITS-1:0]      i_hit_a_x,
    input  wire logic signed [COORD_BITS-1:0]      i_hit_a_y,
    input  wire logic signed [COORD_BITS-1:0]      i_hit_b_x,
    input  wire logic signed [COORD_BITS-1:0]      i_hit_b_y,
    input  wire logic signed [COORD_BITS-1:0]      i_hit_c_x,
    input  wire logic signed [COORD_BITS-1:0]      i_hit_c_y,
    input  wire logic signed [COORD_BITS-1:0]      i_hit_d_x,
    input  wire logic signed [COORD_BITS-1:0]      i_hit_d_y,
    // result words
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic                                   o_compatible,
    output logic signed [tzac_pkg::ANG_W-1:0]      o_first_angle,
    output logic signed [tzac_pkg::ANG_W-1:0]      o_second_angle,
    output logic signed [tzac_pkg::PROD_W-1:0]     o_angle_product
);
    // stage map: 0 turn, 1..IT cordic iterations, then wrap, round, multiply, compare
    localparam int IT = ATAN_ITERATIONS;
    localparam int NS = IT + 5;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    logic signed [tzac_pkg::CFG_W-1:0] r_prod_min, r_prod_max;
    logic signed [tzac_pkg::ZW-1:0]    z_out, z_mid, z_in;
    tzac_pkg::t_reg_idx                reg_idx;

    // a stage loads when it is empty or its content moves on this cycle
    always_comb begin
        en[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--)
            en[k] = !r_vld[k] || en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0])
                r_vld[0] <= i_valid;
            for (int k = 1; k < NS; k++)
                if (en[k])
                    r_vld[k] <= r_vld[k-1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NS-1];

    // configuration registers, one per 32-bit word
    assign reg_idx = tzac_pkg::t_reg_idx'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_min <= tzac_pkg::PROD_MIN_RST;
            r_prod_max <= tzac_pkg::PROD_MAX_RST;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                tzac_pkg::t_reg_prod_min: r_prod_min <= pwdata[tzac_pkg::CFG_W-1:0];
                tzac_pkg::t_reg_prod_max: r_prod_max <= pwdata[tzac_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            tzac_pkg::t_reg_prod_min: prdata = 32'(unsigned'(r_prod_min));
            tzac_pkg::t_reg_prod_max: prdata = 32'(unsigned'(r_prod_max));
            default:                  prdata = '0;
        endcase
    end

    // three lanes: outer b-a, middle c-b, inner d-c
    tzac_lane #(.COORD_BITS(COORD_BITS), .ATAN_ITERATIONS(IT)) u_lane_out (
        .i_clk (i_clk), .i_en (en[IT:0]),
        .i_px (i_hit_a_x), .i_py (i_hit_a_y), .i_qx (i_hit_b_x), .i_qy (i_hit_b_y),
        .o_z (z_out)
    );

    tzac_lane #(.COORD_BITS(COORD_BITS), .ATAN_ITERATIONS(IT)) u_lane_mid (
        .i_clk (i_clk), .i_en (en[IT:0]),
        .i_px (i_hit_b_x), .i_py (i_hit_b_y), .i_qx (i_hit_c_x), .i_qy (i_hit_c_y),
        .o_z (z_mid)
    );

    tzac_lane #(.COORD_BITS(COORD_BITS), .ATAN_ITERATIONS(IT)) u_lane_in (
        .i_clk (i_clk), .i_en (en[IT:0]),
        .i_px (i_hit_c_x), .i_py (i_hit_c_y), .i_qx (i_hit_d_x), .i_qy (i_hit_d_y),
        .o_z (z_in)
    );

    // merge: angle differences, wrap, rounding, product and bound check
    tzac_merge u_merge (
        .i_clk           (i_clk),
        .i_en            (en[NS-1:IT+1]),
        .i_z_out         (z_out),
        .i_z_mid         (z_mid),
        .i_z_in          (z_in),
        .i_prod_min      (r_prod_min),
        .i_prod_max      (r_prod_max),
        .o_compatible    (o_compatible),
        .o_first_angle   (o_first_angle),
        .o_second_angle  (o_second_angle),
        .o_angle_product (o_angle_product)
    );

    // an accepted word always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_vld[0])
        else $error("accepted word lost at pipeline entry");

    // wrapped angles stay within half a turn
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_first_angle >= -15'sd11520) && (o_first_angle <= 15'sd11520)
                 && (o_second_angle >= -15'sd11520) && (o_second_angle <= 15'sd11520))
        else $error("wrapped angle out of range");

    // product word matches its own angles
    a_product: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_angle_product
                    == tzac_pkg::PROD_W'(o_first_angle * o_second_angle))
        else $error("angle product mismatch");

endmodule
`default_nettype wire
